// ===== rtl/radio_device_tracking_table_top_defines.svh =====
// Assertion helpers used by the top-level module.
`ifndef RADIO_DEVICE_TRACKING_TABLE_TOP_DEFINES_SVH
`define RADIO_DEVICE_TRACKING_TABLE_TOP_DEFINES_SVH

// Antecedent implies consequent on the next edge.
`define RDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent on the same edge.
`define RDT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rdt_pkg.sv =====
`timescale 1ns / 1ps
package rdt_pkg;
    localparam int ADDR_W = 48;
    localparam int TIME_W = 32;
    localparam int LVL_W  = 8;
    localparam int CNT_W  = 7;
    localparam int HIT_W  = 16;
    localparam int SLOT_W = 6;
    localparam int SCORE_W = 7;

    localparam logic [1:0] ST_UPDATED  = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;
    localparam logic [1:0] ST_SUMMARY  = 2'd3;

    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_ROUND  = 1'b1;

    localparam logic [0:0] REG_STALE = 1'b0;
    localparam logic [0:0] REG_CLOSE = 1'b1;

    localparam logic [1:0] NF_BLANK   = 2'd1;
    localparam logic [1:0] NF_PRESENT = 2'd2;

    localparam logic signed [LVL_W-1:0] LVL_MIN_INIT = 8'sd127;
    localparam logic signed [LVL_W-1:0] LVL_MAX_INIT = -8'sd127;
    localparam logic [HIT_W-1:0] HIT_MAX = 16'hFFFF;
    localparam logic [1:0] TOP_MASK = 2'b11;
    localparam logic [1:0] TOP_RES = 2'b01;
    localparam logic [1:0] TOP_NONRES = 2'b00;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_AGE,
        S_SCORE,
        S_OUT
    } state_t;

    // One table entry as stored in memory.
    typedef struct packed {
        logic [ADDR_W-1:0]       address;
        logic signed [LVL_W-1:0] level_now;
        logic signed [LVL_W-1:0] level_min;
        logic signed [LVL_W-1:0] level_max;
        logic [1:0]              kind;
        logic                    named;
        logic                    mfg;
        logic [HIT_W-1:0]        hits;
        logic [TIME_W-1:0]       last_seen;
    } entry_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [SLOT_W-1:0]        slot;
        logic [HIT_W-1:0]         hit_count;
        logic signed [LVL_W-1:0]  min_dbm;
        logic signed [LVL_W-1:0]  max_dbm;
        logic [CNT_W-1:0]         device_total;
        logic [CNT_W-1:0]         named_total;
        logic [CNT_W-1:0]         public_total;
        logic [CNT_W-1:0]         private_total;
        logic [CNT_W-1:0]         close_total;
        logic [CNT_W-1:0]         mfg_total;
        logic [SCORE_W-1:0]       exposure_score;
    } result_t;

    typedef struct packed {
        logic                    cmd;
        logic [TIME_W-1:0]       now_ms;
        logic [ADDR_W-1:0]       device_address;
        logic [1:0]              addr_kind;
        logic signed [LVL_W-1:0] signal_dbm;
        logic [1:0]              name_flag;
        logic                    mfg_present;
    } item_t;
endpackage

// ===== rtl/rdt_if.sv =====
`timescale 1ns / 1ps
interface rdt_in_if;
    import rdt_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rdt_out_if;
    import rdt_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rdt_entry_ram.sv =====
`timescale 1ns / 1ps
module rdt_entry_ram #(
    parameter int DEPTH = 64,
    parameter int AW = 6
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  rdt_pkg::entry_t     wdata,
    input  logic [AW-1:0]       raddr,
    output rdt_pkg::entry_t     rdata
);
    import rdt_pkg::*;
    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/radio_device_tracking_table_top.sv =====
`timescale 1ns / 1ps
// Device tracking table. Entries live in a single-port-read, single-port-write
// memory of MAX_ENTRIES rows; valid bits sit in flip-flops and reset clears them.
// Every item walks the whole table through the memory read port, one entry per
// cycle: a report scans for a matching address (remembering the lowest free
// slot), then writes the merged entry back; a round-end item ages out stale
// entries and tallies the survivors in the same walk, then forms the capped
// score. The result sits in an output register; the next item is taken once
// that register is free, so a stalled output holds the input off.
// Configuration is written on cfg_we with cfg_index selecting the stale limit
// (0) or the close threshold (1).
module radio_device_tracking_table_top #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    rdt_in_if.sink      in_ch,
    rdt_out_if.source   out_ch
);
    import rdt_pkg::*;
    `include "radio_device_tracking_table_top_defines.svh"

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int TW = CW + 1;

    // Configuration registers.
    logic [TIME_W-1:0]       stale_reg;
    logic signed [LVL_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_reg <= 32'd45000;
            thr_reg   <= -8'sd60;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_STALE)
            begin
                stale_reg <= cfg_wdata;
            end
            else
            begin
                thr_reg <= cfg_wdata[LVL_W-1:0];
            end
        end
    end

    state_t state_reg, state_next;
    item_t  item_reg;
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [AW:0]  idx_reg, idx_next;   // one extra bit to reach the depth
    logic [AW-1:0] rd_idx_reg;         // index of the entry now on rdata
    logic          rd_live_reg;
    logic          hit_reg, free_reg;
    logic [AW-1:0] hit_slot_reg, free_slot_reg;
    entry_t        hit_entry_reg;
    logic [CW-1:0] dev_reg, named_reg, pub_reg, priv_reg, close_reg, mfg_reg;
    result_t       res_reg, res_next;
    logic          out_valid_reg;

    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata, rdata;
    logic [AW-1:0] raddr;

    assign raddr = idx_reg[AW-1:0];

    rdt_entry_ram #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign in_ch.ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = res_reg;

    logic accept;
    assign accept = in_ch.valid && in_ch.ready;

    // Per-entry examination of the word on rdata.
    logic        cur_valid, cur_match, cur_stale, cur_random, cur_private, cur_keep;
    logic [TIME_W-1:0] age;
    assign cur_valid   = rd_live_reg && valid_reg[rd_idx_reg];
    assign cur_match   = cur_valid && (rdata.address == item_reg.device_address);
    assign age         = item_reg.now_ms - rdata.last_seen;
    assign cur_stale   = age > stale_reg;
    assign cur_keep    = cur_valid && !cur_stale;
    assign cur_random  = rdata.kind[0];
    assign cur_private = cur_random &&
        (((rdata.address[ADDR_W-1 -: 2] & TOP_MASK) == TOP_RES) ||
         ((rdata.address[ADDR_W-1 -: 2] & TOP_MASK) == TOP_NONRES));

    // Merged entry for the write-back of a report.
    entry_t base, merged;
    always_comb
    begin
        base = hit_entry_reg;
        if (!hit_reg)
        begin
            base.address   = item_reg.device_address;
            base.level_min = LVL_MIN_INIT;
            base.level_max = LVL_MAX_INIT;
            base.named     = 1'b0;
            base.hits      = '0;
        end
        merged = base;
        merged.level_now = item_reg.signal_dbm;
        if (item_reg.signal_dbm < base.level_min)
        begin
            merged.level_min = item_reg.signal_dbm;
        end
        if (item_reg.signal_dbm > base.level_max)
        begin
            merged.level_max = item_reg.signal_dbm;
        end
        merged.kind      = item_reg.addr_kind;
        merged.last_seen = item_reg.now_ms;
        if (base.hits != HIT_MAX)
        begin
            merged.hits = base.hits + 1'b1;
        end
        if (item_reg.name_flag == NF_BLANK)
        begin
            merged.named = 1'b0;
        end
        else if (item_reg.name_flag == NF_PRESENT)
        begin
            merged.named = 1'b1;
        end
        merged.mfg = item_reg.mfg_present;
    end

    logic [AW-1:0] tgt_slot;
    assign tgt_slot = hit_reg ? hit_slot_reg : free_slot_reg;
    assign we    = (state_reg == S_WRITE) && (hit_reg || free_reg);
    assign waddr = tgt_slot;
    assign wdata = merged;

    // Score: products of narrow counts by small constants, one add tree.
    logic [TW+5:0] score_sum;
    logic [SCORE_W-1:0] score_cap;
    always_comb
    begin
        score_sum = (TW+6)'(TW'(pub_reg) * 7 + TW'(dev_reg - pub_reg - priv_reg) * 5
                  + TW'(named_reg) * 5 + TW'(close_reg) * 8 + TW'(mfg_reg) * 2);
        if (dev_reg > CW'(12))
        begin
            score_sum = score_sum + (TW+6)'(10);
        end
        if (dev_reg > CW'(24))
        begin
            score_sum = score_sum + (TW+6)'(10);
        end
        score_cap = (score_sum > 100) ? SCORE_W'(100) : score_sum[SCORE_W-1:0];
    end

    // Result word for the closing cycle of an item.
    always_comb
    begin
        res_next = '0;
        if (state_reg == S_SCORE)
        begin
            res_next.status         = ST_SUMMARY;
            res_next.device_total   = CNT_W'(dev_reg);
            res_next.named_total    = CNT_W'(named_reg);
            res_next.public_total   = CNT_W'(pub_reg);
            res_next.private_total  = CNT_W'(priv_reg);
            res_next.close_total    = CNT_W'(close_reg);
            res_next.mfg_total      = CNT_W'(mfg_reg);
            res_next.exposure_score = score_cap;
        end
        else if (hit_reg || free_reg)
        begin
            res_next.status    = hit_reg ? ST_UPDATED : ST_INSERTED;
            res_next.slot      = SLOT_W'(tgt_slot);
            res_next.hit_count = merged.hits;
            res_next.min_dbm   = merged.level_min;
            res_next.max_dbm   = merged.level_max;
        end
        else
        begin
            res_next.status = ST_DROPPED;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    state_next = (in_ch.data.cmd == CMD_ROUND) ? S_AGE : S_SCAN;
                    idx_next   = (AW+1)'(1);
                end
            end
            S_SCAN, S_AGE:
            begin
                if (idx_reg < (AW+1)'(MAX_ENTRIES))
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (!rd_live_reg)
                begin
                    state_next = (state_reg == S_SCAN) ? S_WRITE : S_SCORE;
                end
            end
            S_WRITE, S_SCORE: state_next = S_IDLE;
            default:          state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            rd_live_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            valid_reg     <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            // Track which memory read lands on rdata next cycle.
            rd_live_reg <= accept ||
                (((state_reg == S_SCAN) || (state_reg == S_AGE)) &&
                 (idx_reg < (AW+1)'(MAX_ENTRIES)));
            rd_idx_reg  <= raddr;
            if (accept)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            if (state_reg == S_SCAN && rd_live_reg)
            begin
                if (cur_match && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (!valid_reg[rd_idx_reg] && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (state_reg == S_AGE && cur_valid && cur_stale)
            begin
                valid_reg[rd_idx_reg] <= 1'b0;
            end
            if (we)
            begin
                valid_reg[tgt_slot] <= 1'b1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == S_WRITE) || (state_reg == S_SCORE))
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg  <= in_ch.data;
            dev_reg   <= '0;
            named_reg <= '0;
            pub_reg   <= '0;
            priv_reg  <= '0;
            close_reg <= '0;
            mfg_reg   <= '0;
        end
        if (state_reg == S_SCAN && rd_live_reg)
        begin
            if (cur_match && !hit_reg)
            begin
                hit_slot_reg  <= rd_idx_reg;
                hit_entry_reg <= rdata;
            end
            if (!valid_reg[rd_idx_reg] && !free_reg)
            begin
                free_slot_reg <= rd_idx_reg;
            end
        end
        if (state_reg == S_AGE && cur_keep)
        begin
            dev_reg   <= dev_reg + 1'b1;
            named_reg <= named_reg + CW'(rdata.named);
            pub_reg   <= pub_reg + CW'(!cur_random);
            priv_reg  <= priv_reg + CW'(cur_private);
            close_reg <= close_reg + CW'(rdata.level_now >= thr_reg);
            mfg_reg   <= mfg_reg + CW'(rdata.mfg);
        end
        if ((state_reg == S_WRITE) || (state_reg == S_SCORE))
        begin
            res_reg <= res_next;
        end
    end

    `RDT_ASSERT_SAME(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !in_ch.ready,
        "item accepted while busy")
    `RDT_ASSERT_NEXT(a_write_gives_result, clk, rst_n, state_reg == S_WRITE, out_valid_reg,
        "report finished without result")
    `RDT_ASSERT_NEXT(a_score_gives_result, clk, rst_n, state_reg == S_SCORE,
        out_valid_reg && res_reg.status == ST_SUMMARY, "round end without summary")
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import rdt_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int SETTLE_CYCLES = 80;       // one full table walk plus margin
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int ADDR_POOL     = 90;       // more than the table holds, so drops occur
    localparam int STALL_START   = 3000;
    localparam int STALL_LEN     = 600;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_wdata;

    rdt_in_if  in_ch ();
    rdt_out_if out_ch ();

    radio_device_tracking_table_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Tracker shadow: table contents and register copies.
    logic                    trk_valid [TABLE_DEPTH];
    logic [ADDR_W-1:0]       trk_addr [TABLE_DEPTH];
    logic signed [LVL_W-1:0] trk_now [TABLE_DEPTH];
    logic signed [LVL_W-1:0] trk_min [TABLE_DEPTH];
    logic signed [LVL_W-1:0] trk_max [TABLE_DEPTH];
    logic [1:0]              trk_kind [TABLE_DEPTH];
    logic                    trk_named [TABLE_DEPTH];
    logic                    trk_mfg [TABLE_DEPTH];
    logic [HIT_W-1:0]        trk_hits [TABLE_DEPTH];
    logic [TIME_W-1:0]       trk_seen [TABLE_DEPTH];
    logic [31:0]             stale_ms;
    logic signed [7:0]       close_dbm;

    item_t   pending_items [$];
    result_t expected_results [$];
    logic [ADDR_W-1:0] addr_pool [ADDR_POOL];

    int  error_count;
    int  cycle_count;
    bit  in_idle_on;
    bit  out_idle_on;
    bit  in_taken;
    int  in_gap;
    int  out_gap;
    int  stall_left;
    logic [TIME_W-1:0] clock_ms;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Compute the result of one item and advance the shadow table.
    function automatic result_t track_item(item_t it);
        result_t r;
        int hit;
        int dev, named, pub, rnd, priv, close, mf, score;
        logic is_new;
        r = '0;
        if (it.cmd == CMD_REPORT) begin
            hit = -1;
            is_new = 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (hit < 0 && trk_valid[i] && trk_addr[i] == it.device_address)
                    hit = i;
            if (hit < 0) begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (hit < 0 && !trk_valid[i])
                        hit = i;
                if (hit < 0) begin
                    r.status = ST_DROPPED;
                    return r;
                end
                is_new = 1'b1;
                trk_valid[hit] = 1'b1;
                trk_addr[hit]  = it.device_address;
                trk_min[hit]   = LVL_MIN_INIT;
                trk_max[hit]   = LVL_MAX_INIT;
                trk_named[hit] = 1'b0;
                trk_hits[hit]  = '0;
            end
            trk_now[hit] = it.signal_dbm;
            if (it.signal_dbm < trk_min[hit]) trk_min[hit] = it.signal_dbm;
            if (it.signal_dbm > trk_max[hit]) trk_max[hit] = it.signal_dbm;
            trk_kind[hit] = it.addr_kind;
            trk_seen[hit] = it.now_ms;
            if (trk_hits[hit] != HIT_MAX) trk_hits[hit] = trk_hits[hit] + 1'b1;
            if (it.name_flag == NF_BLANK) trk_named[hit] = 1'b0;
            else if (it.name_flag == NF_PRESENT) trk_named[hit] = 1'b1;
            trk_mfg[hit] = it.mfg_present;
            r.slot      = hit[SLOT_W-1:0];
            r.status    = is_new ? ST_INSERTED : ST_UPDATED;
            r.hit_count = trk_hits[hit];
            r.min_dbm   = trk_min[hit];
            r.max_dbm   = trk_max[hit];
        end
        else begin
            dev = 0; named = 0; pub = 0; rnd = 0; priv = 0; close = 0; mf = 0;
            // Age out first, then tally the survivors.
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (trk_valid[i] && (it.now_ms - trk_seen[i]) > stale_ms)
                    trk_valid[i] = 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (trk_valid[i]) begin
                    dev++;
                    if (trk_named[i]) named++;
                    if (trk_kind[i][0]) begin
                        rnd++;
                        if ((trk_addr[i][47:46] & TOP_MASK) == TOP_RES
                            || (trk_addr[i][47:46] & TOP_MASK) == TOP_NONRES)
                            priv++;
                    end
                    else pub++;
                    if (trk_now[i] >= close_dbm) close++;
                    if (trk_mfg[i]) mf++;
                end
            end
            score = pub * 7 + (rnd - priv) * 5 + named * 5 + close * 8 + mf * 2;
            if (dev > 12) score += 10;
            if (dev > 24) score += 10;
            if (score > 100) score = 100;
            r.status         = ST_SUMMARY;
            r.device_total   = dev[CNT_W-1:0];
            r.named_total    = named[CNT_W-1:0];
            r.public_total   = pub[CNT_W-1:0];
            r.private_total  = priv[CNT_W-1:0];
            r.close_total    = close[CNT_W-1:0];
            r.mfg_total      = mf[CNT_W-1:0];
            r.exposure_score = score[SCORE_W-1:0];
        end
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic item_t make_report(logic [ADDR_W-1:0] a, logic [1:0] kind,
                                          logic signed [7:0] lvl, logic [1:0] nf,
                                          logic mf);
        item_t it;
        it = '0;
        it.cmd            = CMD_REPORT;
        it.now_ms         = clock_ms;
        it.device_address = a;
        it.addr_kind      = kind;
        it.signal_dbm     = lvl;
        it.name_flag      = nf;
        it.mfg_present    = mf;
        return it;
    endfunction

    function automatic item_t make_round();
        item_t it;
        it = '0;
        it.cmd    = CMD_ROUND;
        it.now_ms = clock_ms;
        // Leave random junk in the unused fields; a round ignores them.
        it.device_address = ADDR_W'({$urandom, $urandom});
        it.signal_dbm     = LVL_W'($urandom);
        return it;
    endfunction

    // Random item: mostly reports from a limited address pool, a few round ends.
    function automatic item_t make_random(int pool_used);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) clock_ms = $urandom;                 // big jump, wraps too
        else clock_ms = clock_ms + $urandom_range(0, 1500);
        if (r >= 3 && r < 9) return make_round();
        return make_report(addr_pool[$urandom_range(0, pool_used - 1)],
                           2'($urandom_range(0, 3)), 8'($urandom),
                           2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endfunction

    task automatic write_reg(logic [0:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_STALE) stale_ms = value;
        else close_dbm = value[7:0];
    endtask

    // Hold until every queued item has gone in and every result came back.
    task automatic drain();
        wait (pending_items.size() == 0 && !in_ch.valid && expected_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Input driver: advance to the next item at the falling edge.
    always @(negedge clk) begin
        if (rst_n && !(in_ch.valid && !in_taken)) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_items.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_items.pop_front();
                if (in_idle_on) in_gap <= pick_gap();
            end
            else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Record acceptances and predict at the rising edge.
    always @(posedge clk) begin
        in_taken <= 1'b0;
        if (rst_n && in_ch.valid && in_ch.ready) begin
            expected_results.push_back(track_item(in_ch.data));
            in_taken <= 1'b1;
        end
    end

    // Output ready: random gaps plus one long hold once the run is under way.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end
        else if (cycle_count == STALL_START) begin
            stall_left   <= STALL_LEN;
            out_ch.ready <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (out_gap > 0) begin
            out_gap      <= out_gap - 1;
            out_ch.ready <= 1'b0;
        end
        else begin
            out_ch.ready <= 1'b1;
            if (out_idle_on) out_gap <= pick_gap();
        end
    end

    // Compare each result with the oldest expectation.
    always @(posedge clk) begin
        result_t want;
        result_t got;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (expected_results.size() == 0) begin
                $error("result with no item outstanding");
                error_count++;
            end
            else begin
                want = expected_results.pop_front();
                check_field("slot", want.slot, got.slot);
                check_field("status", want.status, got.status);
                check_field("hit_count", want.hit_count, got.hit_count);
                check_field("min_dbm", want.min_dbm, got.min_dbm);
                check_field("max_dbm", want.max_dbm, got.max_dbm);
                check_field("device_total", want.device_total, got.device_total);
                check_field("named_total", want.named_total, got.named_total);
                check_field("public_total", want.public_total, got.public_total);
                check_field("private_total", want.private_total, got.private_total);
                check_field("close_total", want.close_total, got.close_total);
                check_field("mfg_total", want.mfg_total, got.mfg_total);
                check_field("exposure_score", want.exposure_score, got.exposure_score);
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [31:0] stale_set [5];
        logic [7:0]  close_set [5];
        int pool_used;
        error_count  = 0;
        cycle_count  = 0;
        in_gap       = 0;
        out_gap      = 0;
        stall_left   = 0;
        in_taken     = 1'b0;
        in_idle_on   = 1'b1;
        out_idle_on  = 1'b1;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        clock_ms     = 32'd1000;
        stale_ms     = 32'd45000;
        close_dbm    = -8'sd60;
        for (int i = 0; i < TABLE_DEPTH; i++) trk_valid[i] = 1'b0;
        for (int i = 0; i < ADDR_POOL; i++) addr_pool[i] = ADDR_W'({$urandom, $urandom});
        addr_pool[0] = '1;
        addr_pool[1] = '0;
        addr_pool[2] = 48'h4000_0000_0000;
        addr_pool[3] = 48'h8000_0000_0000;

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: level extremes, every type and name flag, round end.
        pending_items.push_back(make_report(addr_pool[0], 2'd1, -8'sd128, 2'd0, 1'b0));
        pending_items.push_back(make_report(addr_pool[0], 2'd1, -8'sd128, 2'd2, 1'b1));
        pending_items.push_back(make_report(addr_pool[1], 2'd0, 8'sd127, 2'd2, 1'b1));
        pending_items.push_back(make_report(addr_pool[1], 2'd0, 8'sd0, 2'd1, 1'b0));
        pending_items.push_back(make_report(addr_pool[2], 2'd3, -8'sd60, 2'd3, 1'b1));
        pending_items.push_back(make_report(addr_pool[3], 2'd2, -8'sd61, 2'd0, 1'b1));
        pending_items.push_back(make_report(addr_pool[2], 2'd3, 8'sd127, 2'd0, 1'b0));
        pending_items.push_back(make_round());
        clock_ms = clock_ms + 32'd45000;
        pending_items.push_back(make_round());
        clock_ms = clock_ms + 32'd1;
        pending_items.push_back(make_round());
        clock_ms = 32'hFFFF_FFF0;
        pending_items.push_back(make_report(addr_pool[4], 2'd1, -8'sd1, 2'd2, 1'b1));
        clock_ms = 32'h0000_0010;
        pending_items.push_back(make_round());    // age across the wrap
        // Fill the table past capacity so the last reports drop.
        for (int i = 0; i < 70; i++)
            pending_items.push_back(make_report(addr_pool[i % ADDR_POOL + 10 - 10 + i % 1],
                                                2'($urandom_range(0, 3)), 8'($urandom),
                                                2'($urandom_range(0, 3)),
                                                1'($urandom_range(0, 1))));
        pending_items.push_back(make_round());
        drain();

        // Settings sweep, extremes included; the last returns to reset values.
        stale_set = '{32'd0, 32'hFFFF_FFFF, 32'd20000, 32'd3000, 32'd45000};
        close_set = '{8'h80, 8'h7F, 8'hC4, 8'h00, 8'hC4};
        for (int p = 0; p < 5; p++) begin
            write_reg(REG_STALE, stale_set[p]);
            write_reg(REG_CLOSE, {{24{close_set[p][7]}}, close_set[p]});
            in_idle_on  = (p != 1);
            out_idle_on = (p != 3);
            pool_used   = (p == 1) ? ADDR_POOL : $urandom_range(8, ADDR_POOL);
            for (int n = 0; n < 340; n++) pending_items.push_back(make_random(pool_used));
            drain();
        end

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
